// ===== rtl/arm64_address_sequence_relaxer_unit_macros.svh =====
// Assertion macros shared by the relaxer RTL.
`ifndef ARM64_ADDRESS_SEQUENCE_RELAXER_UNIT_MACROS_SVH
`define ARM64_ADDRESS_SEQUENCE_RELAXER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define AASR_ASSERT_NOW(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define AASR_ASSERT_NEXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// ===== rtl/aasr_pkg.sv =====
// Types, encodings and decode helpers of the address sequence relaxer.
`default_nettype none
package aasr_pkg;

   localparam logic [2:0] OP_ADRP_ADD         = 3'd0;
   localparam logic [2:0] OP_ADRP_LDR         = 3'd1;
   localparam logic [2:0] OP_ADRP_LDR_GOT     = 3'd2;
   localparam logic [2:0] OP_ADRP_ADD_LDR     = 3'd3;
   localparam logic [2:0] OP_ADRP_LDR_GOT_LDR = 3'd4;
   localparam logic [2:0] OP_ADRP_ADRP        = 3'd5;

   localparam logic [31:0] ADRP_MASK  = 32'h9f000000;
   localparam logic [31:0] ADRP_MATCH = 32'h90000000;
   localparam logic [31:0] ADD_MASK   = 32'hffc00000;
   localparam logic [31:0] ADD_MATCH  = 32'h91000000;
   localparam logic [31:0] NOP_WORD   = 32'hd503201f;
   localparam logic [31:0] ADR_BASE   = 32'h10000000;
   localparam logic [31:0] LDR_W_LIT  = 32'h18000000;
   localparam logic [31:0] LDR_S_LIT  = 32'h1c000000;
   localparam logic [31:0] LDRSW_LIT  = 32'h98000000;
   localparam logic [31:0] LDR_X_LIT  = 32'h58000000;
   localparam logic [31:0] LDR_D_LIT  = 32'h5c000000;
   localparam logic [31:0] LDR_Q_LIT  = 32'h9c000000;
   localparam logic [31:0] LDST_UIMM  = 32'h39000000;
   localparam logic [31:0] LDST_FP    = 32'h04000000;

   localparam logic [1:0] EXT_ZERO  = 2'd1;
   localparam logic [1:0] EXT_SIGN64 = 2'd2;

   typedef struct packed {
      logic        ok;
      logic [4:0]  dst;
      logic [4:0]  base;
      logic [2:0]  p2;
      logic        fp;
      logic [1:0]  ext;
      logic [15:0] off;
   } load_type;

   function automatic load_type dec_load(input logic [31:0] w);
      load_type l;
      l.ok   = 1'b1;
      l.dst  = w[4:0];
      l.base = w[9:5];
      l.p2   = {1'b0, w[31:30]};
      l.fp   = 1'b0;
      l.ext  = EXT_ZERO;
      if ((w & 32'h3fc00000) == 32'h39400000) begin
         l.ext = EXT_ZERO;
      end else if ((w & 32'h3f800000) == 32'h39800000) begin
         l.ext = w[23:22];
      end else if ((w & 32'h3f400000) == 32'h3d400000) begin
         l.fp = 1'b1;
         if (w[23:22] == 2'd1) begin
            l.p2 = {1'b0, w[31:30]};
         end else if (w[31:30] == 2'd0 && w[23:22] == 2'd3) begin
            l.p2 = 3'd4;
         end else begin
            l.ok = 1'b0;
         end
      end else begin
         l.ok = 1'b0;
      end
      l.off = {4'b0, w[21:10]} << l.p2;
      return l;
   endfunction

   // Distance fits a signed 21-bit value.
   function automatic logic in_range21(input logic [63:0] d);
      return (d[63:20] == '0) || (d[63:20] == '1);
   endfunction

   function automatic logic literal_ok(input load_type l, input logic [63:0] d);
      return (l.p2 > 3'd1) && (d[1:0] == 2'b00) && in_range21(d);
   endfunction

   function automatic logic [31:0] literal_word(input load_type l, input logic [63:0] d);
      logic [31:0] opc;
      if (l.p2 == 3'd2) begin
         opc = l.fp ? LDR_S_LIT : ((l.ext == EXT_SIGN64) ? LDRSW_LIT : LDR_W_LIT);
      end else if (l.p2 == 3'd3) begin
         opc = l.fp ? LDR_D_LIT : LDR_X_LIT;
      end else begin
         opc = LDR_Q_LIT;
      end
      return opc | {8'b0, d[20:2], l.dst};
   endfunction

   function automatic logic immediate_ok(input load_type l, input logic [16:0] off);
      logic [16:0] lowmask;
      logic [16:0] scaled;
      lowmask = ~(17'h1ffff << l.p2);
      scaled  = off >> l.p2;
      return ((off & lowmask) == '0) && (scaled[16:12] == '0);
   endfunction

   function automatic logic [31:0] immediate_word(input load_type l, input logic [4:0] base,
                                                 input logic [16:0] off);
      logic [1:0]  size;
      logic [1:0]  opc;
      logic [16:0] scaled;
      scaled = off >> l.p2;
      if (l.p2 == 3'd4) begin
         size = 2'd0;
         opc  = 2'd3;
      end else begin
         size = l.p2[1:0];
         opc  = l.ext;
      end
      return LDST_UIMM | (l.fp ? LDST_FP : 32'h0) | {size, 30'b0} | {8'b0, opc, 22'b0}
             | {10'b0, scaled[11:0], 10'b0} | {22'b0, base, 5'b0} | {27'b0, l.dst};
   endfunction

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      logic [63:0] a1;
      logic [63:0] a2;
      logic [63:0] a3;
      logic        ad1_ok;
      logic [4:0]  ad1_rd;
      logic [63:0] ad1_pa;
      logic        ad2_ok;
      logic [4:0]  ad2_rd;
      logic [63:0] ad2_pa;
      logic        add_ok;
      logic [4:0]  add_rd;
      logic [4:0]  add_rn;
      logic [11:0] add_imm;
      load_type    ld2;
      load_type    ld3;
      logic [63:0] pg1;
      logic [63:0] pg2;
      logic        page_eq;
      logic [63:0] sum_add;
      logic [63:0] sum_ldr;
      logic [63:0] d_add;
      logic [63:0] d_ldr;
      logic [63:0] d_lit;
   } pipe_type;

endpackage
`default_nettype wire

// ===== rtl/arm64_address_sequence_relaxer_unit.sv =====
// Top level of the ARM64 address sequence relaxer pipeline.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_op, section base, offsets, words
//   rsp     | out       | rsp_valid, rsp_stall, rewritten words, rsp_changed_mask
//
// One hint per cycle while the held result is not refused; each result passes
// through all the register levels below before it is presented.
// Five register levels: decode and address add, page add, offset add,
// distance subtract, then range tests and word rewrite into the output.
// Reset clears the valid bits only; data registers are not reset.
// A stalled output holds the whole pipeline, so nothing is lost or repeated.
`default_nettype none
`include "arm64_address_sequence_relaxer_unit_macros.svh"
module arm64_address_sequence_relaxer_unit
   import aasr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_op,
   input  wire logic [63:0] req_section_base,
   input  wire logic [31:0] req_first_offset,
   input  wire logic [31:0] req_second_offset,
   input  wire logic [31:0] req_third_offset,
   input  wire logic [31:0] req_first_word,
   input  wire logic [31:0] req_second_word,
   input  wire logic [31:0] req_third_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_first_out,
   output logic [31:0]      rsp_second_out,
   output logic [31:0]      rsp_third_out,
   output logic [2:0]       rsp_changed_mask
);

   pipe_type    st_ff [4];
   pipe_type    st_in [4];
   logic [3:0]  vld_ff;
   logic        out_vld_ff;
   logic [31:0] w1_ff, w2_ff, w3_ff, w1_in, w2_in, w3_in;
   logic [2:0]  mask_ff, mask_in;
   logic        adv;

   // Advance everything unless the held result is refused.
   assign adv       = !out_vld_ff || !rsp_stall;
   assign req_stall = !adv;

   // Stage 0: decode the words and form the three addresses.
   always_comb begin
      pipe_type p;
      p = st_ff[0];
      p.op      = req_op;
      p.w1      = req_first_word;
      p.w2      = req_second_word;
      p.w3      = req_third_word;
      p.a1      = req_section_base + {32'b0, req_first_offset};
      p.a2      = req_section_base + {32'b0, req_second_offset};
      p.a3      = req_section_base + {32'b0, req_third_offset};
      p.ad1_ok  = (req_first_word & ADRP_MASK) == ADRP_MATCH;
      p.ad1_rd  = req_first_word[4:0];
      p.ad1_pa  = {{31{req_first_word[23]}}, req_first_word[23:5],
                   req_first_word[30:29], 12'b0};
      p.ad2_ok  = (req_second_word & ADRP_MASK) == ADRP_MATCH;
      p.ad2_rd  = req_second_word[4:0];
      p.ad2_pa  = {{31{req_second_word[23]}}, req_second_word[23:5],
                   req_second_word[30:29], 12'b0};
      p.add_ok  = (req_second_word & ADD_MASK) == ADD_MATCH;
      p.add_rd  = req_second_word[4:0];
      p.add_rn  = req_second_word[9:5];
      p.add_imm = req_second_word[21:10];
      p.ld2     = dec_load(req_second_word);
      p.ld3     = dec_load(req_third_word);
      st_in[0]  = p;
   end

   // Stage 1: referenced pages.
   always_comb begin
      pipe_type p;
      p = st_ff[0];
      p.pg1 = {p.a1[63:12], 12'b0} + p.ad1_pa;
      p.pg2 = {p.a2[63:12], 12'b0} + p.ad2_pa;
      st_in[1] = p;
   end

   // Stage 2: add the page offsets.
   always_comb begin
      pipe_type p;
      p = st_ff[1];
      p.sum_add = p.pg1 + {52'b0, p.add_imm};
      p.sum_ldr = p.pg1 + {48'b0, p.ld2.off};
      p.page_eq = p.pg1 == p.pg2;
      st_in[2] = p;
   end

   // Stage 3: distances from the rewritten instruction.
   always_comb begin
      pipe_type p;
      p = st_ff[2];
      p.d_add = p.sum_add - p.a1;
      p.d_ldr = p.sum_ldr - p.a2;
      p.d_lit = p.sum_add + {48'b0, p.ld3.off} - p.a3;
      st_in[3] = p;
   end

   // Stage 4: pick the rewrite.
   always_comb begin
      pipe_type    p;
      logic        add_ok, ldr_ok, chain3, lit3_ok, imm_ok, pp_ok;
      logic [16:0] im_off;
      logic [31:0] adr_w;
      p      = st_ff[3];
      add_ok = p.ad1_ok && p.add_ok && (p.ad1_rd == p.add_rn) && in_range21(p.d_add);
      ldr_ok = p.ad1_ok && p.ld2.ok && (p.ad1_rd == p.ld2.base)
               && literal_ok(p.ld2, p.d_ldr);
      chain3 = p.ad1_ok && p.add_ok && p.ld3.ok && (p.ad1_rd == p.add_rn)
               && (p.add_rd == p.ld3.base);
      lit3_ok = literal_ok(p.ld3, p.d_lit);
      im_off  = {1'b0, p.ld3.off} + {5'b0, p.add_imm};
      imm_ok  = immediate_ok(p.ld3, im_off);
      pp_ok   = p.ad1_ok && p.ad2_ok && (p.ad1_rd == p.ad2_rd) && p.page_eq;
      adr_w   = ADR_BASE | {1'b0, p.d_add[1:0], 5'b0, p.d_add[20:2], p.add_rd};
      w1_in   = p.w1;
      w2_in   = p.w2;
      w3_in   = p.w3;
      mask_in = 3'b000;
      case (p.op)
         OP_ADRP_ADD, OP_ADRP_LDR_GOT, OP_ADRP_LDR, OP_ADRP_ADD_LDR,
         OP_ADRP_LDR_GOT_LDR: begin
            if ((p.op == OP_ADRP_ADD) || (p.op == OP_ADRP_LDR_GOT && p.add_ok)) begin
               if (add_ok) begin
                  w1_in = adr_w; w2_in = NOP_WORD; mask_in = 3'b011;
               end
            end else if ((p.op == OP_ADRP_LDR)
                         || (p.op == OP_ADRP_LDR_GOT && p.ld2.ok)
                         || (p.op == OP_ADRP_LDR_GOT_LDR && !p.add_ok && p.ld2.ok
                             && p.ld3.ok && p.ld3.base == p.ld2.dst)) begin
               if (ldr_ok) begin
                  w1_in = NOP_WORD; w2_in = literal_word(p.ld2, p.d_ldr);
                  mask_in = 3'b011;
               end
            end else if ((p.op == OP_ADRP_ADD_LDR)
                         || (p.op == OP_ADRP_LDR_GOT_LDR && p.add_ok)) begin
               if (chain3) begin
                  if (lit3_ok) begin
                     w1_in = NOP_WORD; w2_in = NOP_WORD;
                     w3_in = literal_word(p.ld3, p.d_lit); mask_in = 3'b111;
                  end else if (add_ok) begin
                     w1_in = adr_w; w2_in = NOP_WORD; mask_in = 3'b011;
                  end else if (imm_ok) begin
                     w2_in = NOP_WORD; w3_in = immediate_word(p.ld3, p.ad1_rd, im_off);
                     mask_in = 3'b110;
                  end
               end
            end
         end
         OP_ADRP_ADRP: begin
            if (pp_ok) begin
               w2_in = NOP_WORD; mask_in = 3'b010;
            end
         end
         default: begin
            mask_in = 3'b000;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[2:0], req_valid};
         out_vld_ff <= vld_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= st_in[0];
         st_ff[1] <= st_in[1];
         st_ff[2] <= st_in[2];
         st_ff[3] <= st_in[3];
         w1_ff    <= w1_in;
         w2_ff    <= w2_in;
         w3_ff    <= w3_in;
         mask_ff  <= mask_in;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_first_out    = w1_ff;
   assign rsp_second_out   = w2_ff;
   assign rsp_third_out    = w3_ff;
   assign rsp_changed_mask = mask_ff;

   // A rewritten first word always comes with a rewritten second word.
   `AASR_ASSERT_NOW(a_mask_first, rsp_valid && mask_ff[0], mask_ff[1])
   // A rewritten third word always comes with a nop in the second.
   `AASR_ASSERT_NOW(a_mask_third, rsp_valid && mask_ff[2], w2_ff == NOP_WORD)
   // A refused result freezes every stage valid bit.
   `AASR_ASSERT_NEXT(a_hold_pipe, rsp_valid && rsp_stall, $stable(vld_ff))

endmodule
`default_nettype wire
